/* design/isaac_pkg.sv */
// Package for the ISAAC random word generator: beat types, opcodes, sequencer states.
// Depends on nothing; used by isaac_random_word_generator and the testbench.
`default_nettype none
package isaac_pkg;

    localparam logic [31:0] GOLDEN = 32'h9e3779b9;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_INIT = 2'd1,
        OP_NEXT = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] seed_index;
        logic [7:0] seed_byte;
        logic [6:0] seed_length;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] random_word;
        logic        word_valid;
    } out_beat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLR,
        ST_FILL,
        ST_FILL_W,
        ST_GMIX,
        ST_FOLD_RD,
        ST_FOLD_RD_W,
        ST_FOLD_ADD,
        ST_FOLD_MIX,
        ST_FOLD_WR,
        ST_GEN_START,
        ST_GEN_X,
        ST_GEN_M,
        ST_GEN_Y,
        ST_GEN_YW,
        ST_GEN_B,
        ST_GEN_OUT,
        ST_READ,
        ST_READ_W,
        ST_DONE
    } state_t;

    // one step of the eight-word scramble; step k in 0..7
    function automatic logic [255:0] scramble_step(input logic [255:0] vin,
                                                   input logic [2:0] k);
        logic [31:0] v [8];
        logic [31:0] s;
        logic [2:0]  i0, i1, i2, i3;
        logic [255:0] r;
        for (int j = 0; j < 8; j++) v[j] = vin[32*j +: 32];
        i0 = k; i1 = k + 3'd1; i2 = k + 3'd3; i3 = k + 3'd2;
        case (k)
            3'd0: s = v[i1] << 11;
            3'd1: s = v[i1] >> 2;
            3'd2: s = v[i1] << 8;
            3'd3: s = v[i1] >> 16;
            3'd4: s = v[i1] << 10;
            3'd5: s = v[i1] >> 4;
            3'd6: s = v[i1] << 8;
            default: s = v[i1] >> 9;
        endcase
        v[i0] = v[i0] ^ s;
        v[i2] = v[i2] + v[i0];
        v[i1] = v[i1] + v[i3];
        for (int j = 0; j < 8; j++) r[32*j +: 32] = v[j];
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/isaac_ram.sv */
// Single-port word memory with registered read, used for pool and page.
// Depends on nothing.
`default_nettype none
module isaac_ram #(
    parameter int AW = 8
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [31:0]   wdata,
    output logic [31:0]        rdata
);
    logic [31:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* design/isaac_random_word_generator.sv */
// ISAAC random word generator: seed buffer, pool and page memories, and the sequencer.
// Depends on isaac_pkg and isaac_ram.
//
// After reset the block clears both memories, one word per cycle, with the input
// stalled. A load or unused-opcode beat goes straight to the done state. A next beat
// served from the page steps through address, read, result and idle. A next beat on
// an empty page first runs a generation round: a start step, then for each word the
// x, m, y, write, b and out steps on the single-port pool. An init beat clears the
// memories, fills the page byte by byte (skipped for a zero length), scrambles, folds
// twice, eight words at a time, and generates the first page. A finished result waits
// in the output register, so the next beat may be taken and worked on while that
// result is stalled.
`default_nettype none
module isaac_random_word_generator #(
    parameter int LOG_POOL_SIZE  = 8,
    parameter int MAX_SEED_BYTES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire isaac_pkg::in_beat_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output isaac_pkg::out_beat_t   out_data
);
    import isaac_pkg::*;

    localparam int PS = 2**LOG_POOL_SIZE;
    localparam int AW = LOG_POOL_SIZE;
    localparam int BW = AW + 2;
    localparam int SW = (MAX_SEED_BYTES > 1) ? $clog2(MAX_SEED_BYTES) : 1;
    localparam int LW = $clog2(MAX_SEED_BYTES + 1);
    localparam int WLW = AW + 1;

    state_t state_reg, state_next;

    logic [7:0]   seed_mem [MAX_SEED_BYTES];
    logic [7:0]   seed_rd;
    logic [SW-1:0] seed_addr;

    opcode_t       op_reg;
    logic [LW-1:0] len_reg;
    logic [BW-1:0] pos_reg;     // byte position in the page
    logic [LW-1:0] k_reg;       // index inside seed copy
    logic [7:0]    ctr_reg;
    logic [23:0]   word_reg;
    logic [AW-1:0] idx_reg;
    logic [2:0]    step_reg;
    logic [1:0]    mix_cnt_reg;
    logic          pass_reg;    // 0 fold page, 1 fold pool
    logic [255:0]  v_reg;
    logic [31:0]   a_reg, b_reg, cnt_reg, x_reg, y_reg;
    logic [WLW-1:0] left_reg;
    logic [31:0]   res_reg;
    logic          resv_reg;
    logic          out_v_reg;
    out_beat_t     out_reg;

    logic          pool_we, page_we;
    logic [AW-1:0] pool_addr, page_addr;
    logic [31:0]   pool_wd, page_wd, pool_rd, page_rd;

    isaac_ram #(.AW(AW)) u_pool (
        .clk(clk), .we(pool_we), .addr(pool_addr), .wdata(pool_wd), .rdata(pool_rd));
    isaac_ram #(.AW(AW)) u_page (
        .clk(clk), .we(page_we), .addr(page_addr), .wdata(page_wd), .rdata(page_rd));

    logic accept;
    logic out_free;
    logic done_fire;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_v_reg || !out_stall;
    assign done_fire = (state_reg == ST_DONE) && out_free;
    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    logic idx_last;
    logic pos_last;
    logic byte_is_ctr;
    assign idx_last    = (idx_reg == AW'(PS-1));
    assign pos_last    = (pos_reg == BW'(4*PS-1));
    assign byte_is_ctr = (k_reg == len_reg);
    assign seed_addr   = k_reg[SW-1:0];

    logic [WLW-1:0] left_dec;
    logic [AW-1:0]  left_m1;
    assign left_dec = left_reg - 1'b1;
    assign left_m1  = left_dec[AW-1:0];

    logic [LW-1:0] len_sat;
    always_comb
    begin
        if (32'(in_data.seed_length) > 32'(MAX_SEED_BYTES))
            len_sat = LW'(MAX_SEED_BYTES);
        else
            len_sat = LW'(in_data.seed_length);
    end

    logic [31:0] a_shift, a_new;
    always_comb
    begin
        case (idx_reg[1:0])
            2'd0: a_shift = a_reg << 13;
            2'd1: a_shift = a_reg >> 6;
            2'd2: a_shift = a_reg << 2;
            default: a_shift = a_reg >> 16;
        endcase
        a_new = (a_reg ^ a_shift) + pool_rd;
    end

    logic [31:0] y_val, b_val;
    assign y_val = pool_rd + a_reg + b_reg;
    assign b_val = pool_rd + x_reg;

    logic [255:0] v_scr;
    assign v_scr = scramble_step(v_reg, step_reg);

    logic [31:0] v_word;
    assign v_word = v_reg[32*idx_reg[2:0] +: 32];

    logic [AW-1:0] half_idx;
    assign half_idx = idx_reg + AW'(PS/2);

    logic [7:0] fill_byte;
    assign fill_byte = byte_is_ctr ? ctr_reg : seed_rd;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    case (in_data.opcode)
                        OP_INIT: state_next = ST_CLR;
                        OP_NEXT: state_next = (left_reg == '0) ? ST_GEN_START : ST_READ;
                        default: state_next = ST_DONE;
                    endcase
                end
            ST_CLR:
                if (idx_last)
                begin
                    if (op_reg != OP_INIT)
                        state_next = ST_IDLE;
                    else if (len_reg == '0)
                        state_next = ST_GMIX;
                    else
                        state_next = ST_FILL;
                end
            ST_FILL:      state_next = ST_FILL_W;
            ST_FILL_W:    state_next = pos_last ? ST_GMIX : ST_FILL;
            ST_GMIX:
                if (step_reg == 3'd7 && mix_cnt_reg == 2'd3)
                    state_next = ST_FOLD_RD;
            ST_FOLD_RD:   state_next = ST_FOLD_ADD;
            ST_FOLD_ADD:
                state_next = (idx_reg[2:0] == 3'd7) ? ST_FOLD_MIX : ST_FOLD_RD;
            ST_FOLD_MIX:
                if (step_reg == 3'd7) state_next = ST_FOLD_WR;
            ST_FOLD_WR:
                if (idx_reg[2:0] == 3'd7)
                    state_next = (idx_last && pass_reg) ? ST_GEN_START : ST_FOLD_RD;
            ST_GEN_START: state_next = ST_GEN_X;
            ST_GEN_X:     state_next = ST_GEN_M;
            ST_GEN_M:     state_next = ST_GEN_Y;
            ST_GEN_Y:     state_next = ST_GEN_YW;
            ST_GEN_YW:    state_next = ST_GEN_B;
            ST_GEN_B:     state_next = ST_GEN_OUT;
            ST_GEN_OUT:
                if (idx_last)
                    state_next = (op_reg == OP_NEXT) ? ST_READ : ST_DONE;
                else
                    state_next = ST_GEN_X;
            ST_READ:      state_next = ST_READ_W;
            ST_READ_W:    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // memory port control
    always_comb
    begin
        pool_we = 1'b0; page_we = 1'b0;
        pool_addr = idx_reg; page_addr = idx_reg;
        pool_wd = '0; page_wd = '0;
        case (state_reg)
            ST_CLR:
            begin
                pool_we = 1'b1; page_we = 1'b1;
            end
            ST_FILL_W:
            begin
                page_addr = pos_reg[BW-1:2];
                page_we = (pos_reg[1:0] == 2'd3);
                page_wd = {fill_byte, word_reg};
            end
            ST_FOLD_WR:
            begin
                pool_we = 1'b1;
                pool_wd = v_word;
            end
            ST_GEN_M:  pool_addr = half_idx;
            ST_GEN_Y:  pool_addr = x_reg[AW+1:2];
            ST_GEN_YW:
            begin
                pool_we = 1'b1;
                pool_wd = y_val;
            end
            ST_GEN_B:  pool_addr = y_reg[2*AW+1:AW+2];
            ST_GEN_OUT:
            begin
                page_we = 1'b1;
                page_wd = b_val;
            end
            ST_READ:   page_addr = left_m1;
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        seed_rd <= seed_mem[seed_addr];
        if (state_reg == ST_IDLE && accept && in_data.opcode == OP_LOAD
            && 32'(in_data.seed_index) < 32'(MAX_SEED_BYTES))
            seed_mem[SW'(in_data.seed_index)] <= in_data.seed_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            op_reg      <= OP_NONE;
            len_reg     <= '0;
            pos_reg     <= '0;
            k_reg       <= '0;
            ctr_reg     <= '0;
            word_reg    <= '0;
            idx_reg     <= '0;
            step_reg    <= '0;
            mix_cnt_reg <= '0;
            pass_reg    <= 1'b0;
            v_reg       <= '0;
            a_reg       <= '0;
            b_reg       <= '0;
            cnt_reg     <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            left_reg    <= '0;
            res_reg     <= '0;
            resv_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (done_fire)
            begin
                out_v_reg <= 1'b1;
                out_reg.random_word <= res_reg;
                out_reg.word_valid  <= resv_reg;
            end
            else if (!out_stall)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        op_reg <= opcode_t'(in_data.opcode);
                        len_reg <= len_sat;
                        idx_reg <= '0;
                        pos_reg <= '0;
                        k_reg <= '0;
                        ctr_reg <= '0;
                        step_reg <= '0;
                        mix_cnt_reg <= '0;
                        pass_reg <= 1'b0;
                        res_reg <= '0;
                        resv_reg <= 1'b0;
                        v_reg <= {8{GOLDEN}};
                        if (in_data.opcode == OP_INIT)
                        begin
                            a_reg <= '0; b_reg <= '0; cnt_reg <= '0; left_reg <= '0;
                        end
                    end
                ST_CLR:
                    idx_reg <= idx_reg + 1'b1;
                ST_FILL_W:
                begin
                    case (pos_reg[1:0])
                        2'd0: word_reg[7:0] <= fill_byte;
                        2'd1: word_reg[15:8] <= fill_byte;
                        2'd2: word_reg[23:16] <= fill_byte;
                        default: ;
                    endcase
                    pos_reg <= pos_reg + 1'b1;
                    if (byte_is_ctr)
                    begin
                        k_reg <= '0;
                        ctr_reg <= ctr_reg + 1'b1;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_GMIX:
                begin
                    v_reg <= v_scr;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd7) mix_cnt_reg <= mix_cnt_reg + 1'b1;
                end
                ST_FOLD_ADD:
                begin
                    v_reg[32*idx_reg[2:0] +: 32] <= v_word + (pass_reg ? pool_rd : page_rd);
                    if (idx_reg[2:0] == 3'd7)
                        idx_reg <= idx_reg - AW'(7);
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                ST_FOLD_MIX:
                begin
                    v_reg <= v_scr;
                    step_reg <= step_reg + 1'b1;
                end
                ST_FOLD_WR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_last)
                        pass_reg <= 1'b1;
                end
                ST_GEN_START:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    b_reg <= b_reg + cnt_reg + 32'd1;
                end
                ST_GEN_M:  x_reg <= pool_rd;
                ST_GEN_Y:  a_reg <= a_new;
                ST_GEN_YW: y_reg <= y_val;
                ST_GEN_OUT:
                begin
                    b_reg <= b_val;
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_last)
                        left_reg <= WLW'(PS);
                end
                ST_READ:   left_reg <= left_dec;
                ST_READ_W:
                begin
                    res_reg <= page_rd;
                    resv_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* verif/tb_isaac_random_word_generator.sv */
// Testbench for isaac_random_word_generator: directed table then random beats, each result
// checked against an in-bench ISAAC word predictor. Depends on isaac_pkg and the design.
`default_nettype none
module tb_isaac_random_word_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import isaac_pkg::*;

    localparam int POOL = 256;
    localparam int SEED_MAX = 64;
    localparam int IN_W = $bits(in_beat_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_beat_t out_data;

    isaac_random_word_generator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [31:0] pool_m [POOL];
    logic [31:0] page_m [POOL];
    logic [31:0] acc_a, acc_b, pages;
    logic [8:0]  left;
    logic [7:0]  seed_m [SEED_MAX];
    bit          seed_set [SEED_MAX];

    out_beat_t word_queue [$];
    int errors = 0;
    int checked = 0;
    int n_init = 0;
    int n_next = 0;
    bit calm = 1'b0;
    bit hold_out = 1'b0;

    function automatic void gen_round();
        logic [31:0] a, b, x, y, s;
        a = acc_a;
        pages = pages + 32'd1;
        b = acc_b + pages;
        for (int i = 0; i < POOL; i++)
        begin
            x = pool_m[i];
            case (i & 3)
                0: s = a << 13;
                1: s = a >> 6;
                2: s = a << 2;
                default: s = a >> 16;
            endcase
            a = (a ^ s) + pool_m[(i + POOL / 2) % POOL];
            y = pool_m[(x >> 2) % POOL] + a + b;
            pool_m[i] = y;
            b = pool_m[((y >> 8) >> 2) % POOL] + x;
            page_m[i] = b;
        end
        acc_a = a;
        acc_b = b;
    endfunction

    function automatic void mix8(ref logic [31:0] v [8]);
        v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
        v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
        v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
        v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
        v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
        v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
        v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
        v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
    endfunction

    function automatic void fold_pool(input bit from_page, ref logic [31:0] v [8]);
        for (int i = 0; i < POOL; i += 8)
        begin
            for (int j = 0; j < 8; j++)
                v[j] += from_page ? page_m[i + j] : pool_m[i + j];
            mix8(v);
            for (int j = 0; j < 8; j++)
                pool_m[i + j] = v[j];
        end
    endfunction

    function automatic void seed_pool(input int len_in);
        logic [7:0]  bytes [4 * POOL];
        logic [31:0] v [8];
        logic [7:0]  cnt;
        int pos, len;
        len = len_in > SEED_MAX ? SEED_MAX : len_in;
        cnt = 0;
        pos = 0;
        for (int k = 0; k < POOL; k++)
        begin
            pool_m[k] = '0;
            page_m[k] = '0;
        end
        acc_a = 0; acc_b = 0; pages = 0; left = 0;
        if (len > 0)
        begin
            while (4 * POOL - pos > len)
            begin
                for (int k = 0; k < len; k++)
                    bytes[pos + k] = seed_m[k];
                pos += len;
                bytes[pos] = cnt;
                cnt++;
                pos++;
            end
            for (int k = 0; pos + k < 4 * POOL; k++)
                bytes[pos + k] = seed_m[k];
            for (int k = 0; k < POOL; k++)
                page_m[k] = {bytes[4*k+3], bytes[4*k+2], bytes[4*k+1], bytes[4*k]};
        end
        for (int k = 0; k < 8; k++)
            v[k] = GOLDEN;
        for (int k = 0; k < 4; k++)
            mix8(v);
        fold_pool(1'b1, v);
        fold_pool(1'b0, v);
        gen_round();
        left = 9'(POOL);
    endfunction

    function automatic out_beat_t predict_word(input in_beat_t b);
        out_beat_t r;
        r = '0;
        case (opcode_t'(b.opcode))
            OP_LOAD:
            begin
                seed_m[b.seed_index] = b.seed_byte;
                seed_set[b.seed_index] = 1'b1;
            end
            OP_INIT: seed_pool(b.seed_length);
            OP_NEXT:
            begin
                if (left > 0)
                    left = left - 9'd1;
                else
                begin
                    gen_round();
                    left = 9'(POOL - 1);
                end
                r.random_word = page_m[left[7:0]];
                r.word_valid = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // largest length whose bytes have all been written
    function automatic int seed_ok_len();
        int n;
        n = 0;
        while (n < SEED_MAX && seed_set[n])
            n++;
        return n;
    endfunction

    task automatic send_beat(input in_beat_t b, input bit has_fixed, input out_beat_t fixed);
        out_beat_t e;
        if (!calm && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_data <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e = predict_word(b);
        if (has_fixed && e !== fixed)
        begin
            $error("directed row: expected %h got prediction %h", fixed, e);
            errors++;
        end
        word_queue.push_back(has_fixed ? fixed : e);
        if (b.opcode == OP_INIT) n_init++;
        if (b.opcode == OP_NEXT) n_next++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (word_queue.size() > 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_out)
            out_stall <= 1'b1;
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 15);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (word_queue.size() == 0)
            begin
                $error("result beat with nothing expected: %h", out_data);
                errors++;
            end
            else
            begin
                out_beat_t e;
                e = word_queue.pop_front();
                checked++;
                if (out_data.random_word !== e.random_word)
                begin
                    $error("random_word expected %h actual %h", e.random_word,
                           out_data.random_word);
                    errors++;
                end
                if (out_data.word_valid !== e.word_valid)
                begin
                    $error("word_valid expected %b actual %b", e.word_valid,
                           out_data.word_valid);
                    errors++;
                end
            end
        end
    end

    typedef struct {
        in_beat_t  beat;
        bit        has_fixed;
        out_beat_t fixed;
    } row_t;

    function automatic row_t mk(input opcode_t op, input int idx, input int byt,
                                input int len, input bit hf, input logic [32:0] fx);
        row_t r;
        r.beat.opcode = op;
        r.beat.seed_index = 6'(idx);
        r.beat.seed_byte = 8'(byt);
        r.beat.seed_length = 7'(len);
        r.has_fixed = hf;
        r.fixed = fx;
        return r;
    endfunction

    initial
    begin
        row_t rows [$];
        in_beat_t b;
        int k, lim;
        for (int i = 0; i < SEED_MAX; i++)
        begin
            seed_m[i] = '0;
            seed_set[i] = 1'b0;
        end
        for (int i = 0; i < POOL; i++)
        begin
            pool_m[i] = '0;
            page_m[i] = '0;
        end
        acc_a = 0; acc_b = 0; pages = 0; left = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        rows.push_back(mk(OP_NEXT, 0, 0, 0, 1'b0, 33'h0));
        rows.push_back(mk(OP_NONE, 63, 255, 127, 1'b1, 33'h0));
        rows.push_back(mk(OP_INIT, 0, 0, 0, 1'b1, 33'h0));
        rows.push_back(mk(OP_NEXT, 0, 0, 0, 1'b0, 33'h0));
        rows.push_back(mk(OP_LOAD, 0, 8'hff, 0, 1'b1, 33'h0));
        rows.push_back(mk(OP_INIT, 0, 0, 1, 1'b1, 33'h0));
        rows.push_back(mk(OP_NEXT, 0, 0, 0, 1'b0, 33'h0));
        rows.push_back(mk(OP_LOAD, 1, 8'h00, 0, 1'b1, 33'h0));
        rows.push_back(mk(OP_LOAD, 2, 8'h5a, 0, 1'b1, 33'h0));
        rows.push_back(mk(OP_INIT, 0, 0, 3, 1'b1, 33'h0));
        rows.push_back(mk(OP_NEXT, 0, 0, 0, 1'b0, 33'h0));
        rows.push_back(mk(OP_NEXT, 0, 0, 0, 1'b0, 33'h0));
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].has_fixed, rows[i].fixed);

        for (int i = 3; i < SEED_MAX; i++)
        begin
            b = '0;
            b.opcode = OP_LOAD;
            b.seed_index = 6'(i);
            b.seed_byte = 8'($urandom);
            send_beat(b, 0, '0);
        end
        b = '0; b.opcode = OP_INIT; b.seed_length = 7'd64;
        send_beat(b, 0, '0);
        b.seed_length = 7'd127;
        send_beat(b, 0, '0);
        drain();

        // hold off the result side while beats keep coming
        hold_out = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_out = 1'b0;
            end
            for (int i = 0; i < 20; i++)
            begin
                b = '0; b.opcode = OP_NEXT;
                send_beat(b, 0, '0);
            end
        join
        drain();

        // page rollover with no idling
        calm = 1'b1;
        for (int i = 0; i < 260; i++)
        begin
            b = '0; b.opcode = OP_NEXT;
            b.seed_index = 6'($urandom); b.seed_byte = 8'($urandom);
            send_beat(b, 0, '0);
        end
        calm = 1'b0;

        k = 0;
        while (k < 195)
        begin
            lim = seed_ok_len();
            b = IN_W'($urandom);
            case ($urandom_range(99))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                    b.opcode = OP_LOAD;
                12, 13:
                begin
                    b.opcode = OP_INIT;
                    b.seed_length = 7'((lim == SEED_MAX && $urandom_range(1))
                                    ? $urandom_range(127, 64) : $urandom_range(lim));
                end
                14, 15: b.opcode = OP_NONE;
                default: b.opcode = OP_NEXT;
            endcase
            send_beat(b, 0, '0);
            k++;
        end
        drain();
        repeat (50) @(negedge clk);
        $display("Checked %0d result beats: %0d inits, %0d words, page rollovers and stalls.",
                 checked, n_init, n_next);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout waiting for the design");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire
